### rtl/fcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// fixed-frame checker.
// ----------------------------------------------------------------------------
package fcc_pkg;

    // CRC-16/CCITT-FALSE: polynomial 0x1021, initial value 0xFFFF, MSB first.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam int          CRC_BYTES = 2;

    // Smallest payload length of a heartbeat frame.
    localparam logic [7:0]  HB_MIN_LEN = 8'd8;

    // Depth of the queue between the front and back parts.
    localparam int          QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [1:0]  CFG_MAGIC    = 2'd0;
    localparam logic [1:0]  CFG_VERSION  = 2'd1;
    localparam logic [1:0]  CFG_MAX_LEN  = 2'd2;
    localparam logic [1:0]  CFG_HB_ID    = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] RST_MAGIC    = 16'hA55A;
    localparam logic [7:0]  RST_VERSION  = 8'd1;
    localparam logic [7:0]  RST_MAX_LEN  = 8'd22;
    localparam logic [7:0]  RST_HB_ID    = 8'd1;

    // Verdict error codes.
    localparam logic [2:0]  ERR_NONE     = 3'd0;
    localparam logic [2:0]  ERR_MAGIC    = 3'd1;
    localparam logic [2:0]  ERR_VERSION  = 3'd2;
    localparam logic [2:0]  ERR_LENGTH   = 3'd3;
    localparam logic [2:0]  ERR_CRC      = 3'd4;

    // Byte classes produced by the front part.
    localparam logic [2:0]  KIND_HDR     = 3'd0;  // header byte, slot 0..7
    localparam logic [2:0]  KIND_HB      = 3'd1;  // heartbeat payload byte, slot 0..7
    localparam logic [2:0]  KIND_BODY    = 3'd2;  // other byte covered by the CRC
    localparam logic [2:0]  KIND_CRC_LO  = 3'd3;  // received CRC, low byte
    localparam logic [2:0]  KIND_CRC_HI  = 3'd4;  // received CRC, high byte (last)

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic [2:0] slot;
    } t_item;

    typedef struct packed {
        logic [15:0] magic;
        logic [7:0]  version;
        logic [7:0]  max_len;
        logic [7:0]  hb_id;
    } t_cfg;

    // One byte of CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

### rtl/fcc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_front
// Tracks the byte position within the frame and classifies each accepted
// byte before it is queued for the back part.
// ----------------------------------------------------------------------------
module fcc_front
    import fcc_pkg::*;
#(
    parameter int FRAME_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_start_of_frame,
    output logic        o_push,
    output t_item       o_item,
    input  logic        i_push_ready
);

    localparam int POS_W     = $clog2(FRAME_BYTES);
    localparam int LAST_DATA = FRAME_BYTES - CRC_BYTES;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] w_pos;
    logic [2:0]       w_kind;

    // A start flag realigns the byte to position zero.
    assign w_pos = i_start_of_frame ? '0 : r_pos;

    // Classify the byte by its position in the frame.
    always_comb begin
        if (w_pos < POS_W'(8)) begin
            w_kind = KIND_HDR;
        end else if (w_pos < POS_W'(16)) begin
            w_kind = KIND_HB;
        end else if (w_pos < POS_W'(LAST_DATA)) begin
            w_kind = KIND_BODY;
        end else if (w_pos == POS_W'(LAST_DATA)) begin
            w_kind = KIND_CRC_LO;
        end else begin
            w_kind = KIND_CRC_HI;
        end
    end

    assign o_in_ready  = i_push_ready;
    assign o_push      = i_in_valid & i_push_ready;
    assign o_item.data = i_rx_byte;
    assign o_item.kind = w_kind;
    assign o_item.slot = w_pos[2:0];

    // The last byte wraps the position back to the start of the frame.
    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (w_kind == KIND_CRC_HI) begin
                n_pos = '0;
            end else begin
                n_pos = w_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

### rtl/fcc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_queue
// Short first-in first-out queue of classified bytes between the front and
// back parts.
// ----------------------------------------------------------------------------
module fcc_queue
    import fcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_push_item,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_item o_pop_item,
    input  logic  i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_slots[r_rd_ptr];
    assign w_push       = i_push & o_push_ready;
    assign w_pop        = i_pop & o_pop_valid;

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/fcc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_back
// Runs the CRC, captures header and heartbeat bytes and forms the verdict
// in an output register on the last byte of each frame.
// ----------------------------------------------------------------------------
module fcc_back
    import fcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_ok,
    output logic [2:0]  o_error_code,
    output logic [7:0]  o_sequence_res,
    output logic [7:0]  o_message_id,
    output logic [7:0]  o_frame_flags,
    output logic [7:0]  o_payload_len,
    output logic        o_is_heartbeat,
    output logic [31:0] o_sender_uptime,
    output logic [7:0]  o_sender_role,
    output logic [7:0]  o_sender_version,
    output logic [15:0] o_sender_errors
);

    logic [15:0] r_crc;
    logic [7:0]  r_hdr [8];
    logic [7:0]  r_hb  [8];
    logic [7:0]  r_crc_lo;
    logic        r_out_valid;
    logic        r_frame_ok;
    logic [2:0]  r_error_code;
    logic [7:0]  r_sequence_res;
    logic [7:0]  r_message_id;
    logic [7:0]  r_frame_flags;
    logic [7:0]  r_payload_len;
    logic        r_is_heartbeat;
    logic [31:0] r_sender_uptime;
    logic [7:0]  r_sender_role;
    logic [7:0]  r_sender_version;
    logic [15:0] r_sender_errors;

    logic [15:0] w_crc_base;
    logic [15:0] w_crc_next;
    logic        w_last;
    logic [2:0]  w_err;
    logic        w_ok;
    logic        w_hb;

    // Take a byte whenever the output register is free or being emptied.
    assign o_pop  = i_q_valid & (~r_out_valid | i_out_ready);
    assign w_last = o_pop & (i_item.kind == KIND_CRC_HI);

    // Byte zero of a frame restarts the CRC.
    assign w_crc_base = ((i_item.kind == KIND_HDR) && (i_item.slot == 3'd0)) ?
                        CRC_INIT : r_crc;
    assign w_crc_next = crc16_update(w_crc_base, i_item.data);

    // Verdict checks in priority order; the first failure wins.
    always_comb begin
        if ({r_hdr[1], r_hdr[0]} != i_cfg.magic) begin
            w_err = ERR_MAGIC;
        end else if (r_hdr[2] != i_cfg.version) begin
            w_err = ERR_VERSION;
        end else if (r_hdr[6] > i_cfg.max_len) begin
            w_err = ERR_LENGTH;
        end else if ({i_item.data, r_crc_lo} != r_crc) begin
            w_err = ERR_CRC;
        end else begin
            w_err = ERR_NONE;
        end
    end

    assign w_ok = (w_err == ERR_NONE);
    assign w_hb = w_ok && (r_hdr[4] == i_cfg.hb_id) && (r_hdr[6] >= HB_MIN_LEN);

    // CRC accumulator and byte stores.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (o_pop) begin
            case (i_item.kind)
                KIND_HDR, KIND_HB, KIND_BODY: begin
                    r_crc <= w_crc_next;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            case (i_item.kind)
                KIND_HDR: begin
                    r_hdr[i_item.slot] <= i_item.data;
                end
                KIND_HB: begin
                    r_hb[i_item.slot] <= i_item.data;
                end
                KIND_CRC_LO: begin
                    r_crc_lo <= i_item.data;
                end
                default: begin
                end
            endcase
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload; heartbeat fields read as zero otherwise.
    always_ff @(posedge i_clk) begin
        if (w_last) begin
            r_frame_ok       <= w_ok;
            r_error_code     <= w_err;
            r_sequence_res   <= r_hdr[3];
            r_message_id     <= r_hdr[4];
            r_frame_flags    <= r_hdr[5];
            r_payload_len    <= r_hdr[6];
            r_is_heartbeat   <= w_hb;
            r_sender_uptime  <= w_hb ? {r_hb[3], r_hb[2], r_hb[1], r_hb[0]} : 32'd0;
            r_sender_role    <= w_hb ? r_hb[4] : 8'd0;
            r_sender_version <= w_hb ? r_hb[5] : 8'd0;
            r_sender_errors  <= w_hb ? {r_hb[7], r_hb[6]} : 16'd0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_ok       = r_frame_ok;
    assign o_error_code     = r_error_code;
    assign o_sequence_res   = r_sequence_res;
    assign o_message_id     = r_message_id;
    assign o_frame_flags    = r_frame_flags;
    assign o_payload_len    = r_payload_len;
    assign o_is_heartbeat   = r_is_heartbeat;
    assign o_sender_uptime  = r_sender_uptime;
    assign o_sender_role    = r_sender_role;
    assign o_sender_version = r_sender_version;
    assign o_sender_errors  = r_sender_errors;

endmodule

### rtl/fixed_frame_checker_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_frame_checker_crc16
// Checks fixed-length frames protected by CRC-16/CCITT-FALSE, one byte per
// transaction, and gives one verdict per frame with header and heartbeat
// fields.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+--------------------------------------
//  in       | i_in_valid / o_in_ready  | i_rx_byte, i_start_of_frame
//  out      | o_out_valid / i_out_ready| o_frame_ok, o_error_code, header and
//           |                          | heartbeat fields
//  cfg      | i_cfg_we (no wait)       | i_cfg_addr, i_cfg_wdata
//
// One byte is accepted per cycle while o_in_ready is high; the byte-wide CRC
// update in the back part sets the cycle. A verdict is registered when the back
// part takes the last byte of its frame from the queue.
// A stalled output fills the two-entry queue, after which o_in_ready drops.
// Reset is synchronous and active low and needs no clearing pass.
// ----------------------------------------------------------------------------
module fixed_frame_checker_crc16
    import fcc_pkg::*;
#(
    parameter int FRAME_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_start_of_frame,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_ok,
    output logic [2:0]  o_error_code,
    output logic [7:0]  o_sequence_res,
    output logic [7:0]  o_message_id,
    output logic [7:0]  o_frame_flags,
    output logic [7:0]  o_payload_len,
    output logic        o_is_heartbeat,
    output logic [31:0] o_sender_uptime,
    output logic [7:0]  o_sender_role,
    output logic [7:0]  o_sender_version,
    output logic [15:0] o_sender_errors
);

    t_cfg  r_cfg;
    logic  w_push;
    logic  w_push_ready;
    t_item w_push_item;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic   <= RST_MAGIC;
            r_cfg.version <= RST_VERSION;
            r_cfg.max_len <= RST_MAX_LEN;
            r_cfg.hb_id   <= RST_HB_ID;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAGIC:   r_cfg.magic   <= i_cfg_wdata;
                CFG_VERSION: r_cfg.version <= i_cfg_wdata[7:0];
                CFG_MAX_LEN: r_cfg.max_len <= i_cfg_wdata[7:0];
                CFG_HB_ID:   r_cfg.hb_id   <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Front part: position tracking and classification.
    fcc_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_start_of_frame (i_start_of_frame),
        .o_push           (w_push),
        .o_item           (w_push_item),
        .i_push_ready     (w_push_ready)
    );

    // Queue between the two parts.
    fcc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_item  (w_push_item),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_q_valid),
        .o_pop_item   (w_q_item),
        .i_pop        (w_pop)
    );

    // Back part: CRC, stores and verdict.
    fcc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_valid        (w_q_valid),
        .i_item           (w_q_item),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_frame_ok       (o_frame_ok),
        .o_error_code     (o_error_code),
        .o_sequence_res   (o_sequence_res),
        .o_message_id     (o_message_id),
        .o_frame_flags    (o_frame_flags),
        .o_payload_len    (o_payload_len),
        .o_is_heartbeat   (o_is_heartbeat),
        .o_sender_uptime  (o_sender_uptime),
        .o_sender_role    (o_sender_role),
        .o_sender_version (o_sender_version),
        .o_sender_errors  (o_sender_errors)
    );

    // A heartbeat verdict is only given for a frame that passed every check.
    a_hb_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_heartbeat) |-> o_frame_ok)
        else $error("heartbeat flagged on a failed frame");

    // The pass flag and the error code agree.
    a_ok_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_ok == (o_error_code == ERR_NONE)))
        else $error("frame_ok disagrees with error_code");

    // Heartbeat fields are cleared when the frame is not a heartbeat.
    a_hb_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_heartbeat) |->
            (o_sender_uptime == 32'd0 && o_sender_role == 8'd0 &&
             o_sender_version == 8'd0 && o_sender_errors == 16'd0))
        else $error("heartbeat fields not cleared");

    // The back part only takes a byte the queue actually holds.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from an empty queue");

endmodule
